/* rtl/tfr_pkg.sv */
// Shared types and codes for the texel format to RGBA8 converter.
package tfr_pkg;

  // Input beat: one 32-byte texel, lane_a holds bytes 0 to 7
  typedef struct packed {
    logic [63:0] lane_a;
    logic [63:0] lane_b;
    logic [63:0] lane_c;
    logic [63:0] lane_d;
  } tfr_in_t;

  // Result beat: RGBA8 color plus combination-valid flag
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       ok;
  } tfr_out_t;

  typedef logic [2:0] layout_t;
  typedef logic [3:0] comp_type_t;

  // Configuration port widths and register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_TYPE = 8'd1;

  // Channel layouts
  localparam layout_t LAY_RGB   = 3'd0;
  localparam layout_t LAY_RGBA  = 3'd1;
  localparam layout_t LAY_BGR   = 3'd2;
  localparam layout_t LAY_BGRA  = 3'd3;
  localparam layout_t LAY_A     = 3'd4;
  localparam layout_t LAY_L     = 3'd5;
  localparam layout_t LAY_LA    = 3'd6;
  localparam layout_t LAY_BAD   = 3'd7;

  // Component types
  localparam comp_type_t TYPE_S8       = 4'd0;
  localparam comp_type_t TYPE_U8       = 4'd1;
  localparam comp_type_t TYPE_S16      = 4'd2;
  localparam comp_type_t TYPE_U16      = 4'd3;
  localparam comp_type_t TYPE_S32      = 4'd4;
  localparam comp_type_t TYPE_U32      = 4'd5;
  localparam comp_type_t TYPE_F32      = 4'd6;
  localparam comp_type_t TYPE_F64      = 4'd7;
  localparam comp_type_t TYPE_PK4444   = 4'd8;
  localparam comp_type_t TYPE_PK5551   = 4'd9;
  localparam comp_type_t TYPE_PK8888   = 4'd12;
  localparam comp_type_t TYPE_PK4444R  = 4'd13;

  localparam layout_t    LAYOUT_RESET    = LAY_RGBA;
  localparam comp_type_t COMP_TYPE_RESET = TYPE_U8;

endpackage

/* rtl/texel_format_to_rgba8_unit.sv */
// Top level: texel format to RGBA8 converter with config registers and pipeline.
//
//   Channel | Direction | Handshake           | Beat
//   in_     | in        | in_valid / in_stall | tfr_in_t: 32-byte texel
//   out_    | out       | out_valid/out_stall | tfr_out_t: RGBA8 plus ok
//   cfg_    | in        | cfg_valid/cfg_ready | register index and data
//
// Two register stages: an input register, then one pass of decode logic
// into the result register, which drives the output; a result leaves when
// out_stall is low. One beat per cycle is sustained while the output is
// not stalled; the float64 shift-subtract and barrel shift set the longest
// path. rst_n clears both valid flags and loads layout RGBA and type unorm8.
// A stalled output holds its beat while the input register still takes a
// new one; in_stall rises only when both registers are full and the output
// is stalled. cfg_ready is always high.
module texel_format_to_rgba8_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tfr_pkg::tfr_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tfr_pkg::tfr_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tfr_pkg::*;

  layout_t    layout_r;
  comp_type_t comp_type_r;

  tfr_in_t    in_r;
  logic       in_vld_r;
  tfr_out_t   out_r;
  tfr_out_t   out_nxt;
  logic       out_vld_r;
  logic       out_adv;
  logic       in_load;

  logic [255:0] texel;
  logic [7:0]   scal [4];
  logic [7:0]   comp [4];
  logic [15:0]  pk16;
  logic [31:0]  pk32;
  logic         is_scalar;
  logic         is_packed;
  logic         four_comp;
  logic         ok;

  // floor(x*255/31) for a 5-bit field: reciprocal estimate plus one correction
  function automatic logic [7:0] scale5(input logic [4:0] x);
    logic [12:0] y;
    logic [17:0] prod;
    logic [7:0]  q0;
    logic [12:0] rem;
    y    = {x, 8'b0} - {8'b0, x};
    prod = {y, 5'b0} + {5'b0, y};
    q0   = prod[17:10];
    rem  = y - ({q0, 5'b0} - {5'b0, q0});
    return q0 + {7'b0, (rem >= 13'd31)};
  endfunction

  // Configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r    <= LAYOUT_RESET;
      comp_type_r <= COMP_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LAYOUT) begin
        layout_r <= cfg_data[2:0];
      end else if (cfg_index == REG_COMP_TYPE) begin
        comp_type_r <= cfg_data[3:0];
      end
    end
  end

  // Pipeline control: advance each stage when the one after it is free
  assign out_adv   = !out_vld_r || !out_stall;
  assign in_load   = !in_vld_r || out_adv;
  assign in_stall  = !in_load;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_r <= in_valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_r <= in_data;
    end
    if (out_adv && in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  // Scalar components at byte offset i times the scalar size
  assign texel = {in_r.lane_d, in_r.lane_c, in_r.lane_b, in_r.lane_a};

  for (genvar i = 0; i < 4; i++) begin : g_comp
    tfr_comp u_comp (
      .comp_type (comp_type_r),
      .raw8      (texel[8*i +: 8]),
      .raw16     (texel[16*i +: 16]),
      .raw32     (texel[32*i +: 32]),
      .raw64     (texel[64*i +: 64]),
      .comp_byte (scal[i])
    );
  end

  // Packed formats read the first bytes of the texel
  assign pk16 = in_r.lane_a[15:0];
  assign pk32 = in_r.lane_a[31:0];

  always_comb begin
    case (comp_type_r)
      TYPE_PK4444: begin
        comp[0] = {pk16[15:12], pk16[15:12]};
        comp[1] = {pk16[11:8],  pk16[11:8]};
        comp[2] = {pk16[7:4],   pk16[7:4]};
        comp[3] = {pk16[3:0],   pk16[3:0]};
      end
      TYPE_PK4444R: begin
        comp[0] = {pk16[3:0],   pk16[3:0]};
        comp[1] = {pk16[7:4],   pk16[7:4]};
        comp[2] = {pk16[11:8],  pk16[11:8]};
        comp[3] = {pk16[15:12], pk16[15:12]};
      end
      TYPE_PK5551: begin
        comp[0] = scale5(pk16[15:11]);
        comp[1] = scale5(pk16[10:6]);
        comp[2] = scale5(pk16[5:1]);
        comp[3] = pk16[0] ? 8'hFF : 8'h00;
      end
      TYPE_PK8888: begin
        comp[0] = pk32[31:24];
        comp[1] = pk32[23:16];
        comp[2] = pk32[15:8];
        comp[3] = pk32[7:0];
      end
      default: begin
        comp[0] = scal[0];
        comp[1] = scal[1];
        comp[2] = scal[2];
        comp[3] = scal[3];
      end
    endcase
  end

  // Combination check: packed types need a four-component layout; layout 7 and undefined types are invalid
  assign is_scalar = (comp_type_r <= TYPE_F64);
  assign is_packed = (comp_type_r == TYPE_PK4444) || (comp_type_r == TYPE_PK4444R) ||
                     (comp_type_r == TYPE_PK5551) || (comp_type_r == TYPE_PK8888);
  assign four_comp = (layout_r == LAY_RGBA) || (layout_r == LAY_BGRA);
  assign ok = (layout_r != LAY_BAD) && (is_scalar || (is_packed && four_comp));

  // Place components into R, G, B, A
  always_comb begin
    out_nxt.ok = ok;
    case (layout_r)
      LAY_RGB: begin
        out_nxt.red = comp[0]; out_nxt.green = comp[1];
        out_nxt.blue = comp[2]; out_nxt.alpha = 8'hFF;
      end
      LAY_RGBA: begin
        out_nxt.red = comp[0]; out_nxt.green = comp[1];
        out_nxt.blue = comp[2]; out_nxt.alpha = comp[3];
      end
      LAY_BGR: begin
        out_nxt.red = comp[2]; out_nxt.green = comp[1];
        out_nxt.blue = comp[0]; out_nxt.alpha = 8'hFF;
      end
      LAY_BGRA: begin
        out_nxt.red = comp[2]; out_nxt.green = comp[1];
        out_nxt.blue = comp[0]; out_nxt.alpha = comp[3];
      end
      LAY_A: begin
        out_nxt.red = 8'hFF; out_nxt.green = 8'hFF;
        out_nxt.blue = 8'hFF; out_nxt.alpha = comp[0];
      end
      LAY_L: begin
        out_nxt.red = comp[0]; out_nxt.green = comp[0];
        out_nxt.blue = comp[0]; out_nxt.alpha = 8'hFF;
      end
      LAY_LA: begin
        out_nxt.red = comp[0]; out_nxt.green = comp[0];
        out_nxt.blue = comp[0]; out_nxt.alpha = comp[1];
      end
      default: begin
        out_nxt.red = 8'h00; out_nxt.green = 8'h00;
        out_nxt.blue = 8'h00; out_nxt.alpha = 8'h00;
      end
    endcase
    // Zero the color on an invalid combination
    if (!ok) begin
      out_nxt.red   = 8'h00;
      out_nxt.green = 8'h00;
      out_nxt.blue  = 8'h00;
      out_nxt.alpha = 8'h00;
    end
  end

endmodule

/* rtl/tfr_comp.sv */
// One scalar component: normalized integer or IEEE float/double to a byte.
module tfr_comp (
  input  tfr_pkg::comp_type_t comp_type,
  input  logic [7:0]          raw8,
  input  logic [15:0]         raw16,
  input  logic [31:0]         raw32,
  input  logic [63:0]         raw64,
  output logic [7:0]          comp_byte
);
  import tfr_pkg::*;

  logic [7:0]  q_s8;

  logic [23:0] s16_n;
  logic [16:0] s16_r;
  logic [7:0]  q_s16;

  logic [24:0] u16_n;
  logic [17:0] u16_r;
  logic [7:0]  q_u16;

  logic [39:0] s32_n;
  logic [32:0] s32_r;
  logic [7:0]  q_s32;

  logic [40:0] u32_n;
  logic [33:0] u32_r;
  logic [7:0]  q_u32;

  logic [7:0]  f_ex;
  logic [23:0] f_m;
  logic [31:0] f_p;
  logic [7:0]  f_amt;
  logic [31:0] f_sh;
  logic [9:0]  f_t;
  logic [7:0]  f_rnd;
  logic [7:0]  q_f32;

  logic [10:0] d_ex;
  logic [52:0] d_m;
  logic [60:0] d_p;
  logic [10:0] d_amt;
  logic [60:0] d_sh;
  logic [9:0]  d_t;
  logic [7:0]  d_rnd;
  logic [7:0]  q_f64;

  // s8: round(x*255/127) reduces to 2x plus one when x >= 64
  assign q_s8 = raw8[7] ? 8'd0 : {raw8[6:0], raw8[6]};

  // Normalized integers: N = 510x + max over D = 2^k - 2.
  // Estimate N >> k is at most one short; the remainder is N mod 2^k + 2*q0.
  assign s16_n = {raw16[14:0], 9'b0} - {8'b0, raw16[14:0], 1'b0} + 24'd32767;
  assign s16_r = {1'b0, s16_n[15:0]} + {8'b0, s16_n[23:16], 1'b0};
  assign q_s16 = raw16[15] ? 8'd0
               : s16_n[23:16] + {7'b0, (s16_r >= 17'd65534)};

  assign u16_n = {raw16, 9'b0} - {8'b0, raw16, 1'b0} + 25'd65535;
  assign u16_r = {1'b0, u16_n[16:0]} + {9'b0, u16_n[24:17], 1'b0};
  assign q_u16 = u16_n[24:17] + {7'b0, (u16_r >= 18'd131070)};

  assign s32_n = {raw32[30:0], 9'b0} - {8'b0, raw32[30:0], 1'b0} + 40'h00_7FFF_FFFF;
  assign s32_r = {1'b0, s32_n[31:0]} + {24'b0, s32_n[39:32], 1'b0};
  assign q_s32 = raw32[31] ? 8'd0
               : s32_n[39:32] + {7'b0, (s32_r >= 33'h0_FFFF_FFFE)};

  assign u32_n = {raw32, 9'b0} - {8'b0, raw32, 1'b0} + 41'h000_FFFF_FFFF;
  assign u32_r = {1'b0, u32_n[32:0]} + {25'b0, u32_n[40:33], 1'b0};
  assign q_u32 = u32_n[40:33] + {7'b0, (u32_r >= 34'h1_FFFF_FFFE)};

  // float32: in-range result is ((m*255) >> (149 - ex) + 1) >> 1
  assign f_ex  = raw32[30:23];
  assign f_m   = {1'b1, raw32[22:0]};
  assign f_p   = {f_m, 8'b0} - {8'b0, f_m};
  assign f_amt = 8'd149 - f_ex;
  assign f_sh  = f_p >> f_amt;
  assign f_t   = f_sh[9:0] + 10'd1;
  assign f_rnd = f_t[8:1];

  always_comb begin
    if (f_ex == 8'hFF) begin
      q_f32 = ((raw32[22:0] != 23'd0) || !raw32[31]) ? 8'hFF : 8'h00;
    end else if (raw32[31] || (f_ex == 8'd0)) begin
      q_f32 = 8'h00;
    end else if (f_ex >= 8'd127) begin
      q_f32 = 8'hFF;
    end else if (f_ex < 8'd117) begin
      q_f32 = 8'h00;
    end else begin
      q_f32 = f_rnd;
    end
  end

  // float64: in-range result is ((m*255) >> (1074 - ex) + 1) >> 1
  assign d_ex  = raw64[62:52];
  assign d_m   = {1'b1, raw64[51:0]};
  assign d_p   = {d_m, 8'b0} - {8'b0, d_m};
  assign d_amt = 11'd1074 - d_ex;
  assign d_sh  = d_p >> d_amt;
  assign d_t   = d_sh[9:0] + 10'd1;
  assign d_rnd = d_t[8:1];

  always_comb begin
    if (d_ex == 11'h7FF) begin
      q_f64 = ((raw64[51:0] != 52'd0) || !raw64[63]) ? 8'hFF : 8'h00;
    end else if (raw64[63] || (d_ex == 11'd0)) begin
      q_f64 = 8'h00;
    end else if (d_ex >= 11'd1023) begin
      q_f64 = 8'hFF;
    end else if (d_ex < 11'd1013) begin
      q_f64 = 8'h00;
    end else begin
      q_f64 = d_rnd;
    end
  end

  // Select by component type; packed types are decoded elsewhere
  always_comb begin
    case (comp_type)
      TYPE_S8:  comp_byte = q_s8;
      TYPE_U8:  comp_byte = raw8;
      TYPE_S16: comp_byte = q_s16;
      TYPE_U16: comp_byte = q_u16;
      TYPE_S32: comp_byte = q_s32;
      TYPE_U32: comp_byte = q_u32;
      TYPE_F32: comp_byte = q_f32;
      TYPE_F64: comp_byte = q_f64;
      default:  comp_byte = 8'h00;
    endcase
  end

endmodule
